[design/bcc_pkg.sv]
package bcc_pkg;

    localparam int PITCH_W = 17;
    localparam int GAIN_W  = 21;
    localparam int LIMIT_W = 15;
    localparam int RATE_W  = 16;
    localparam int SPEED_W = 15;
    localparam int DRIVE_W = 16;
    localparam int FILT_W  = 17;
    localparam int INTEG_W = 15;
    localparam int DIFF_W  = PITCH_W + 1;
    localparam int ERR_W   = SPEED_W + 1;
    localparam int FX_W    = 21;
    localparam int IS_W    = 20;
    localparam int MUL_W   = 22;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int ACC_W   = 48;
    localparam int TERM_W  = 32;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = GAIN_W;

    localparam int FULL_SPEED_STEP = 200;
    localparam int TURN_SPAN       = 40;
    localparam int INTEGRAL_BOUND  = 10000;

    localparam int DIV10_SHIFT = 24;
    localparam int Q_W         = FX_W - 1;
    localparam logic signed [MUL_W-1:0] DIV10_RECIP = MUL_W'((1 << DIV10_SHIFT) / 10);

    localparam int UPRIGHT_SHIFT = 16;
    localparam int SPEED_SHIFT   = 8;
    localparam int TURN_SHIFT    = 9;

    typedef enum logic [IDX_W-1:0] {
        REG_BALANCE_ANGLE,
        REG_UPRIGHT_P_GAIN,
        REG_UPRIGHT_D_GAIN,
        REG_SPEED_P_GAIN,
        REG_SPEED_I_GAIN,
        REG_TURN_P_GAIN,
        REG_TURN_D_GAIN,
        REG_DRIVE_LIMIT
    } reg_idx_t;

    localparam logic [1:0] MODE_STOP         = 2'd0;
    localparam logic [1:0] MODE_FORWARD_HALF = 2'd1;
    localparam logic [1:0] MODE_BACK_HALF    = 2'd2;
    localparam logic [1:0] MODE_FULL_FORWARD = 2'd3;

    localparam logic [1:0] TURN_STRAIGHT = 2'd0;
    localparam logic [1:0] TURN_LEFT     = 2'd1;
    localparam logic [1:0] TURN_RIGHT    = 2'd2;

    typedef struct packed {
        logic signed [PITCH_W-1:0] balance_angle;
        logic signed [GAIN_W-1:0]  upright_p_gain;
        logic signed [GAIN_W-1:0]  upright_d_gain;
        logic signed [GAIN_W-1:0]  speed_p_gain;
        logic signed [GAIN_W-1:0]  speed_i_gain;
        logic signed [GAIN_W-1:0]  turn_p_gain;
        logic signed [GAIN_W-1:0]  turn_d_gain;
        logic [LIMIT_W-1:0]        drive_limit;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_P,
        ST_UP_D,
        ST_DIV10,
        ST_FILT,
        ST_INTEG,
        ST_SP_I,
        ST_SP_SUM,
        ST_TN_P,
        ST_TN_D,
        ST_TURN,
        ST_DRIVE
    } state_t;

    function automatic logic signed [ACC_W-1:0] trunc_div_pow2(
        input logic signed [ACC_W-1:0] v,
        input int unsigned sh
    );
        logic [ACC_W-1:0] bias;
        bias = v[ACC_W-1] ? ((ACC_W'(1) << sh) - ACC_W'(1)) : '0;
        return (v + signed'(bias)) >>> sh;
    endfunction

    function automatic logic signed [DRIVE_W-1:0] clamp_drive(
        input logic signed [TERM_W-1:0] v,
        input logic [LIMIT_W-1:0] lim
    );
        logic signed [TERM_W-1:0] lim_s;
        logic signed [TERM_W-1:0] r;
        lim_s = signed'(TERM_W'(lim));
        if (v > lim_s)
        begin
            r = lim_s;
        end
        else if (v < -lim_s)
        begin
            r = -lim_s;
        end
        else
        begin
            r = v;
        end
        return r[DRIVE_W-1:0];
    endfunction

    function automatic logic signed [IS_W-1:0] movement_of(input logic [1:0] mode);
        logic signed [IS_W-1:0] m;
        case (mode)
            MODE_FORWARD_HALF: m = IS_W'(FULL_SPEED_STEP / 2);
            MODE_BACK_HALF:    m = -IS_W'(FULL_SPEED_STEP / 2);
            MODE_FULL_FORWARD: m = IS_W'(FULL_SPEED_STEP);
            default:           m = '0;
        endcase
        return m;
    endfunction

endpackage

[design/bcc_sample_if.sv]
interface bcc_sample_if;
    logic                               valid;
    logic                               ready;
    logic signed [bcc_pkg::PITCH_W-1:0] pitch_angle;
    logic signed [bcc_pkg::RATE_W-1:0]  pitch_rate;
    logic signed [bcc_pkg::RATE_W-1:0]  yaw_rate;
    logic signed [bcc_pkg::SPEED_W-1:0] wheel_speed;
    logic [1:0]                         motion_mode;
    logic [1:0]                         turn_command;
    logic                               tipped_over;

    modport source (
        output valid, pitch_angle, pitch_rate, yaw_rate, wheel_speed,
               motion_mode, turn_command, tipped_over,
        input  ready
    );
    modport sink (
        input  valid, pitch_angle, pitch_rate, yaw_rate, wheel_speed,
               motion_mode, turn_command, tipped_over,
        output ready
    );
endinterface

[design/bcc_result_if.sv]
interface bcc_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [bcc_pkg::DRIVE_W-1:0] left_drive;
    logic signed [bcc_pkg::DRIVE_W-1:0] right_drive;
    logic                               drive_enable;

    modport source (
        output valid, left_drive, right_drive, drive_enable,
        input  ready
    );
    modport sink (
        input  valid, left_drive, right_drive, drive_enable,
        output ready
    );
endinterface

[design/bcc_cfg_if.sv]
interface bcc_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [bcc_pkg::IDX_W-1:0]   reg_index;
    logic [bcc_pkg::DATA_W-1:0]  wdata;

    modport source (
        output valid, reg_index, wdata,
        input  ready
    );
    modport sink (
        input  valid, reg_index, wdata,
        output ready
    );
endinterface

[design/balance_cascade_controller_top.sv]
// two-wheel balance controller: upright pd, speed pi and turn loops in cascade
// sample channel: one item per control period with pitch, rates, wheel speed,
// motion mode, turn command and the tipped flag; accepted on valid and ready
// result channel: one item per sample with left and right drive, each clamped
// to +-drive_limit, and drive_enable (low when tipped)
// cfg channel: register index and data, always ready, written between samples
// one sample at a time: the step sequencer runs six products and one
// divide-by-ten through a single 22x22 multiplier, and takes a new sample
// only once the last one has reached the output register
// the result sits in an output register until taken; the next sample is
// accepted meanwhile; the final step waits only while it is full and untaken
// reset: registers return to their defaults, the speed filter and integral
// clear, no result is pending and the block is ready for a sample
module balance_cascade_controller_top (
    input  logic          clk,
    input  logic          rst_n,
    bcc_sample_if.sink    sample,
    bcc_result_if.source  result,
    bcc_cfg_if.sink       cfg
);

    bcc_pkg::cfg_t   regs;
    bcc_pkg::state_t state_reg;
    bcc_pkg::state_t state_next;

    logic signed [bcc_pkg::DIFF_W-1:0]  diff_reg;
    logic signed [bcc_pkg::RATE_W-1:0]  prate_reg;
    logic signed [bcc_pkg::RATE_W-1:0]  yrate_reg;
    logic signed [bcc_pkg::ERR_W-1:0]   err_reg;
    logic [1:0]                         mode_reg;
    logic [1:0]                         turn_cmd_reg;
    logic                               tipped_reg;
    logic [bcc_pkg::Q_W-1:0]            fx_abs_reg;
    logic                               fx_neg_reg;

    logic signed [bcc_pkg::FILT_W-1:0]  filt_reg;
    logic signed [bcc_pkg::FILT_W-1:0]  filt_next;
    logic signed [bcc_pkg::INTEG_W-1:0] integ_reg;
    logic signed [bcc_pkg::INTEG_W-1:0] integ_next;

    logic signed [bcc_pkg::ACC_W-1:0]   acc_reg;
    logic signed [bcc_pkg::TERM_W-1:0]  upright_reg;
    logic signed [bcc_pkg::TERM_W-1:0]  speed_reg;
    logic signed [bcc_pkg::TERM_W-1:0]  turn_reg;
    logic signed [bcc_pkg::TERM_W-1:0]  pwm_reg;

    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic signed [bcc_pkg::DRIVE_W-1:0] left_reg;
    logic signed [bcc_pkg::DRIVE_W-1:0] right_reg;
    logic                               enable_reg;

    logic signed [bcc_pkg::MUL_W-1:0]   mul_a;
    logic signed [bcc_pkg::MUL_W-1:0]   mul_b;
    logic signed [bcc_pkg::PROD_W-1:0]  prod;
    logic signed [bcc_pkg::ACC_W-1:0]   prod_ext;

    logic                               accept;
    logic                               out_free;

    logic signed [bcc_pkg::ERR_W-1:0]   err_in;
    logic signed [bcc_pkg::FX_W-1:0]    err_x;
    logic signed [bcc_pkg::FX_W-1:0]    filt_x;
    logic signed [bcc_pkg::FX_W-1:0]    fx;
    logic signed [bcc_pkg::FX_W-1:0]    fx_mag;

    logic [bcc_pkg::Q_W-1:0]            q0;
    logic [bcc_pkg::Q_W+2:0]            ten_q;
    logic [bcc_pkg::Q_W+2:0]            rem;
    logic [bcc_pkg::Q_W-1:0]            q;
    logic signed [bcc_pkg::FX_W-1:0]    q_s;
    logic signed [bcc_pkg::FX_W-1:0]    filt_val;

    logic signed [bcc_pkg::IS_W-1:0]    isum;
    logic signed [bcc_pkg::IS_W-1:0]    ibound;
    logic signed [bcc_pkg::IS_W-1:0]    iclamp;

    logic signed [bcc_pkg::GAIN_W-1:0]  kd_turn;
    logic signed [bcc_pkg::MUL_W-1:0]   target2;

    bcc_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    bcc_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign prod_ext = bcc_pkg::ACC_W'(prod);

    assign sample.ready = (state_reg == bcc_pkg::ST_IDLE);
    assign accept       = sample.valid && (state_reg == bcc_pkg::ST_IDLE);
    assign out_free     = !out_valid_reg || result.ready;

    assign result.valid        = out_valid_reg;
    assign result.left_drive   = left_reg;
    assign result.right_drive  = right_reg;
    assign result.drive_enable = enable_reg;

    // speed error and low-pass numerator
    assign err_in = -bcc_pkg::ERR_W'(sample.wheel_speed);
    assign err_x  = bcc_pkg::FX_W'(err_in);
    assign filt_x = bcc_pkg::FX_W'(filt_reg);
    assign fx     = (err_x <<< 1) + err_x + (filt_x <<< 3) - filt_x;
    assign fx_mag = fx[bcc_pkg::FX_W-1] ? -fx : fx;

    // divide by ten: reciprocal product, then one correction step
    assign q0    = prod[bcc_pkg::DIV10_SHIFT +: bcc_pkg::Q_W];
    assign ten_q = {q0, 3'b000} + {2'b00, q0, 1'b0};
    assign rem   = {3'b000, fx_abs_reg} - ten_q;
    assign q     = (rem >= (bcc_pkg::Q_W + 3)'(10)) ? q0 + 1'b1 : q0;
    assign q_s   = signed'({1'b0, q});
    assign filt_val  = fx_neg_reg ? -q_s : q_s;
    assign filt_next = filt_val[bcc_pkg::FILT_W-1:0];

    // integral with clamp
    assign ibound = bcc_pkg::IS_W'(bcc_pkg::INTEGRAL_BOUND);
    assign isum   = bcc_pkg::IS_W'(integ_reg) + bcc_pkg::IS_W'(filt_reg)
                  + bcc_pkg::movement_of(mode_reg);
    always_comb
    begin
        if (isum > ibound)
        begin
            iclamp = ibound;
        end
        else if (isum < -ibound)
        begin
            iclamp = -ibound;
        end
        else
        begin
            iclamp = isum;
        end
    end
    assign integ_next = iclamp[bcc_pkg::INTEG_W-1:0];

    // turn operands
    assign kd_turn = (mode_reg == bcc_pkg::MODE_FORWARD_HALF ||
                      mode_reg == bcc_pkg::MODE_BACK_HALF) ? regs.turn_d_gain : '0;
    always_comb
    begin
        case (turn_cmd_reg)
            bcc_pkg::TURN_LEFT:  target2 = -bcc_pkg::MUL_W'(bcc_pkg::TURN_SPAN);
            bcc_pkg::TURN_RIGHT: target2 = bcc_pkg::MUL_W'(bcc_pkg::TURN_SPAN);
            default:             target2 = '0;
        endcase
    end

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            bcc_pkg::ST_UP_P:
            begin
                mul_a = bcc_pkg::MUL_W'(diff_reg);
                mul_b = bcc_pkg::MUL_W'(regs.upright_p_gain);
            end
            bcc_pkg::ST_UP_D:
            begin
                mul_a = bcc_pkg::MUL_W'(prate_reg);
                mul_b = bcc_pkg::MUL_W'(regs.upright_d_gain);
            end
            bcc_pkg::ST_DIV10:
            begin
                mul_a = signed'(bcc_pkg::MUL_W'(fx_abs_reg));
                mul_b = bcc_pkg::DIV10_RECIP;
            end
            bcc_pkg::ST_FILT:
            begin
                mul_a = bcc_pkg::MUL_W'(err_reg);
                mul_b = bcc_pkg::MUL_W'(regs.speed_p_gain);
            end
            bcc_pkg::ST_SP_I:
            begin
                mul_a = bcc_pkg::MUL_W'(integ_reg);
                mul_b = bcc_pkg::MUL_W'(regs.speed_i_gain);
            end
            bcc_pkg::ST_SP_SUM:
            begin
                mul_a = target2;
                mul_b = bcc_pkg::MUL_W'(regs.turn_p_gain);
            end
            bcc_pkg::ST_TN_P:
            begin
                mul_a = bcc_pkg::MUL_W'(yrate_reg);
                mul_b = bcc_pkg::MUL_W'(kd_turn);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            bcc_pkg::ST_IDLE:
            begin
                if (sample.valid)
                begin
                    state_next = bcc_pkg::ST_UP_P;
                end
            end
            bcc_pkg::ST_UP_P:   state_next = bcc_pkg::ST_UP_D;
            bcc_pkg::ST_UP_D:   state_next = bcc_pkg::ST_DIV10;
            bcc_pkg::ST_DIV10:  state_next = bcc_pkg::ST_FILT;
            bcc_pkg::ST_FILT:   state_next = bcc_pkg::ST_INTEG;
            bcc_pkg::ST_INTEG:  state_next = bcc_pkg::ST_SP_I;
            bcc_pkg::ST_SP_I:   state_next = bcc_pkg::ST_SP_SUM;
            bcc_pkg::ST_SP_SUM: state_next = bcc_pkg::ST_TN_P;
            bcc_pkg::ST_TN_P:   state_next = bcc_pkg::ST_TN_D;
            bcc_pkg::ST_TN_D:   state_next = bcc_pkg::ST_TURN;
            bcc_pkg::ST_TURN:   state_next = bcc_pkg::ST_DRIVE;
            bcc_pkg::ST_DRIVE:
            begin
                if (out_free)
                begin
                    state_next     = bcc_pkg::ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: state_next = bcc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bcc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            filt_reg      <= '0;
            integ_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == bcc_pkg::ST_FILT)
            begin
                filt_reg <= filt_next;
            end
            if (state_reg == bcc_pkg::ST_INTEG)
            begin
                integ_reg <= integ_next;
            end
            else if (state_reg == bcc_pkg::ST_SP_I && tipped_reg)
            begin
                integ_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            diff_reg     <= bcc_pkg::DIFF_W'(sample.pitch_angle)
                          - bcc_pkg::DIFF_W'(regs.balance_angle);
            prate_reg    <= sample.pitch_rate;
            yrate_reg    <= sample.yaw_rate;
            err_reg      <= err_in;
            mode_reg     <= sample.motion_mode;
            turn_cmd_reg <= sample.turn_command;
            tipped_reg   <= sample.tipped_over;
            fx_abs_reg   <= fx_mag[bcc_pkg::Q_W-1:0];
            fx_neg_reg   <= fx[bcc_pkg::FX_W-1];
        end
        case (state_reg)
            bcc_pkg::ST_UP_D:   acc_reg <= prod_ext;
            bcc_pkg::ST_DIV10:  acc_reg <= acc_reg + (prod_ext <<< 8);
            bcc_pkg::ST_FILT:
                upright_reg <= bcc_pkg::TERM_W'(
                    bcc_pkg::trunc_div_pow2(acc_reg, bcc_pkg::UPRIGHT_SHIFT));
            bcc_pkg::ST_INTEG:  acc_reg <= prod_ext;
            bcc_pkg::ST_SP_SUM: acc_reg <= acc_reg + prod_ext;
            bcc_pkg::ST_TN_P:
            begin
                speed_reg <= bcc_pkg::TERM_W'(
                    bcc_pkg::trunc_div_pow2(acc_reg, bcc_pkg::SPEED_SHIFT));
                acc_reg <= prod_ext;
            end
            bcc_pkg::ST_TN_D:   acc_reg <= acc_reg + (prod_ext <<< 1);
            bcc_pkg::ST_TURN:
            begin
                turn_reg <= bcc_pkg::TERM_W'(
                    bcc_pkg::trunc_div_pow2(acc_reg, bcc_pkg::TURN_SHIFT));
                pwm_reg  <= upright_reg + speed_reg;
            end
            bcc_pkg::ST_DRIVE:
            begin
                if (out_free)
                begin
                    left_reg   <= bcc_pkg::clamp_drive(pwm_reg - turn_reg, regs.drive_limit);
                    right_reg  <= bcc_pkg::clamp_drive(pwm_reg + turn_reg, regs.drive_limit);
                    enable_reg <= !tipped_reg;
                end
            end
            default: acc_reg <= acc_reg;
        endcase
    end

endmodule

[design/bcc_mul.sv]
module bcc_mul (
    input  logic                               clk,
    input  logic signed [bcc_pkg::MUL_W-1:0]   a,
    input  logic signed [bcc_pkg::MUL_W-1:0]   b,
    output logic signed [bcc_pkg::PROD_W-1:0]  prod
);

    logic signed [bcc_pkg::PROD_W-1:0] prod_reg;
    logic signed [bcc_pkg::PROD_W-1:0] prod_next;

    assign prod_next = bcc_pkg::PROD_W'(a) * bcc_pkg::PROD_W'(b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

[design/bcc_cfg.sv]
module bcc_cfg (
    input  logic          clk,
    input  logic          rst_n,
    bcc_cfg_if.sink       cfg,
    output bcc_pkg::cfg_t regs
);

    bcc_pkg::cfg_t regs_reg;
    bcc_pkg::cfg_t regs_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (bcc_pkg::reg_idx_t'(cfg.reg_index))
                bcc_pkg::REG_BALANCE_ANGLE:
                    regs_next.balance_angle = cfg.wdata[bcc_pkg::PITCH_W-1:0];
                bcc_pkg::REG_UPRIGHT_P_GAIN: regs_next.upright_p_gain = cfg.wdata;
                bcc_pkg::REG_UPRIGHT_D_GAIN: regs_next.upright_d_gain = cfg.wdata;
                bcc_pkg::REG_SPEED_P_GAIN:   regs_next.speed_p_gain   = cfg.wdata;
                bcc_pkg::REG_SPEED_I_GAIN:   regs_next.speed_i_gain   = cfg.wdata;
                bcc_pkg::REG_TURN_P_GAIN:    regs_next.turn_p_gain    = cfg.wdata;
                bcc_pkg::REG_TURN_D_GAIN:    regs_next.turn_d_gain    = cfg.wdata;
                bcc_pkg::REG_DRIVE_LIMIT:
                    regs_next.drive_limit = cfg.wdata[bcc_pkg::LIMIT_W-1:0];
                default: regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.balance_angle  <= -17'sd2688;
            regs_reg.upright_p_gain <= -21'sd84480;
            regs_reg.upright_d_gain <= -21'sd563;
            regs_reg.speed_p_gain   <= 21'sd28160;
            regs_reg.speed_i_gain   <= 21'sd141;
            regs_reg.turn_p_gain    <= 21'sd10240;
            regs_reg.turn_d_gain    <= 21'sd0;
            regs_reg.drive_limit    <= 15'd7200;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

    assign regs = regs_reg;

endmodule
